FILE: sv/assert_macros.svh
// Assertion macros used by the checker file tcwc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/tcwc_pkg.sv
package tcwc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned ADDR_W = 2;
	localparam int unsigned SEGMENT_BYTES_DEF = 1024;
	localparam logic [WORD_W-1:0] SSTHRESH_RST = 32'd64000;

	// Phase codes
	localparam logic [1:0] PH_SLOW  = 2'd0;
	localparam logic [1:0] PH_AVOID = 2'd1;
	localparam logic [1:0] PH_REC   = 2'd2;

	// Classification of an item
	localparam logic [1:0] KIND_NEW     = 2'd0;
	localparam logic [1:0] KIND_DUP     = 2'd1;
	localparam logic [1:0] KIND_STALE   = 2'd2;
	localparam logic [1:0] KIND_TIMEOUT = 2'd3;

	localparam logic [7:0] DUP_FR_COUNT = 8'd3;

	typedef struct packed {
		logic              wr;
		logic [WORD_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic capture;
		logic calc;
		logic div_start;
		logic add_quot;
		logic limit;
		logic put;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
		logic out_free;
	} ctrl_status_t;

	function automatic logic [WORD_W-1:0] sat_add(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W] ? '1 : s[WORD_W-1:0];
	endfunction

endpackage

FILE: sv/tcwc_item_if.sv
interface tcwc_item_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] ack_number;

	modport source (output valid, output func, output ack_number, input ready);
	modport sink (input valid, input func, input ack_number, output ready);
endinterface

FILE: sv/tcwc_result_if.sv
interface tcwc_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] window_bytes;
	logic [31:0] threshold_bytes;
	logic [31:0] send_limit;
	logic [1:0]  phase;
	logic [1:0]  ack_kind;
	logic        fast_retransmit;

	modport source (output valid, output window_bytes, output threshold_bytes,
		output send_limit, output phase, output ack_kind, output fast_retransmit,
		input ready);
	modport sink (input valid, input window_bytes, input threshold_bytes,
		input send_limit, input phase, input ack_kind, input fast_retransmit,
		output ready);
endinterface

FILE: sv/tcwc_apb.sv
module tcwc_apb import tcwc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [WORD_W-1:0] pwdata,
	output logic [WORD_W-1:0] prdata,
	output logic              pready,
	output cfg_wr_t           cfg
);

	localparam logic [ADDR_W-1:0] ADDR_SSTHRESH = '0;

	logic [WORD_W-1:0] init_ssthresh_q;
	logic              hit;

	assign hit    = (paddr == ADDR_SSTHRESH);
	assign pready = 1'b1;

	always_comb begin
		cfg.wr   = psel && penable && pwrite && hit;
		cfg.data = pwdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_ssthresh_q <= SSTHRESH_RST;
		end else if (cfg.wr) begin
			init_ssthresh_q <= pwdata;
		end
	end

	assign prdata = hit ? init_ssthresh_q : '0;

endmodule

FILE: sv/tcwc_div.sv
module tcwc_div import tcwc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] quotient
);

	localparam int unsigned STEP_W = $clog2(WORD_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] dvd_q;
	logic [WORD_W-1:0] dsr_q;
	logic [WORD_W-1:0] quot_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   diff;
	logic              fits;

	// Restoring division, one quotient bit per cycle, most significant first.
	assign trial = {rem_q, dvd_q[WORD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
			dvd_q  <= {dvd_q[WORD_W-2:0], 1'b0};
			quot_q <= {quot_q[WORD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

FILE: sv/tcwc_dp.sv
module tcwc_dp import tcwc_pkg::*; #(
	parameter int unsigned SEGMENT_BYTES = SEGMENT_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_wr_t           cfg,
	input  ctrl_cmd_t         cmd,
	output ctrl_status_t      status,
	input  logic              in_func,
	input  logic [WORD_W-1:0] in_ack,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] out_window,
	output logic [WORD_W-1:0] out_threshold,
	output logic [WORD_W-1:0] out_limit,
	output logic [1:0]        out_phase,
	output logic [1:0]        out_kind,
	output logic              out_fast
);

	localparam logic [63:0] SEG_SQ_W = 64'(SEGMENT_BYTES) * 64'(SEGMENT_BYTES);
	localparam logic [WORD_W-1:0] SEG    = WORD_W'(SEGMENT_BYTES);
	localparam logic [WORD_W-1:0] SEG3   = WORD_W'(3 * SEGMENT_BYTES);
	localparam logic [WORD_W-1:0] SEG_SQ = SEG_SQ_W[WORD_W-1:0];

	// Engine state
	logic [WORD_W-1:0] window_q;
	logic [WORD_W-1:0] threshold_q;
	logic [1:0]        phase_q;
	logic [7:0]        dup_q;
	logic [WORD_W-1:0] highest_q;
	logic [WORD_W-1:0] last_q;
	logic [WORD_W-1:0] limit_q;

	// Current item and its per-item flags
	logic              item_func_q;
	logic [WORD_W-1:0] item_ack_q;
	logic [1:0]        kind_q;
	logic              fast_q;
	logic              load_q;
	logic              chk_q;

	// Result word
	logic              out_valid_q;
	logic [WORD_W-1:0] out_window_q;
	logic [WORD_W-1:0] out_threshold_q;
	logic [WORD_W-1:0] out_limit_q;
	logic [1:0]        out_phase_q;
	logic [1:0]        out_kind_q;
	logic              out_fast_q;

	logic [WORD_W-1:0] win_n;
	logic [WORD_W-1:0] thr_n;
	logic [1:0]        ph_n;
	logic [7:0]        dup_n;
	logic [7:0]        dup_inc;
	logic [WORD_W-1:0] hi_n;
	logic [WORD_W-1:0] last_n;
	logic [1:0]        kind_n;
	logic              fast_n;
	logic              load_n;
	logic              chk_n;
	logic              need_div;
	logic              div_done;
	logic [WORD_W-1:0] quot;

	tcwc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (SEG_SQ),
		.divisor  (window_q),
		.done     (div_done),
		.quotient (quot)
	);

	// Classification and the window updates, with a divider request in congestion avoidance.
	always_comb begin
		win_n    = window_q;
		thr_n    = threshold_q;
		ph_n     = phase_q;
		dup_n    = dup_q;
		hi_n     = highest_q;
		last_n   = last_q;
		kind_n   = KIND_STALE;
		fast_n   = 1'b0;
		load_n   = 1'b0;
		chk_n    = 1'b0;
		need_div = 1'b0;
		dup_inc  = (dup_q != 8'hFF) ? dup_q + 8'd1 : dup_q;
		if (item_func_q) begin
			kind_n = KIND_TIMEOUT;
			dup_n  = '0;
			thr_n  = window_q >> 1;
			ph_n   = PH_SLOW;
			win_n  = SEG;
			load_n = 1'b1;
		end else begin
			last_n = item_ack_q;
			if (item_ack_q > highest_q) begin
				kind_n = KIND_NEW;
				hi_n   = item_ack_q;
				dup_n  = '0;
				load_n = 1'b1;
				case (phase_q)
					PH_AVOID: begin
						// The growth step comes from the divider.
						if (window_q != '0) begin
							need_div = 1'b1;
						end else begin
							win_n = SEG;
						end
					end
					PH_REC: begin
						win_n = threshold_q;
						ph_n  = PH_AVOID;
					end
					default: begin
						win_n = sat_add(window_q, SEG);
						chk_n = 1'b1;
					end
				endcase
			end else if (item_ack_q == highest_q) begin
				kind_n = KIND_DUP;
				dup_n  = dup_inc;
				if (dup_inc == DUP_FR_COUNT && phase_q != PH_REC) begin
					ph_n   = PH_REC;
					thr_n  = window_q >> 1;
					win_n  = sat_add(window_q >> 1, SEG3);
					fast_n = 1'b1;
					load_n = 1'b1;
				end else if (phase_q == PH_REC) begin
					win_n  = sat_add(window_q, SEG);
					load_n = 1'b1;
				end
			end
		end
	end

	always_comb begin
		status.need_div = need_div;
		status.div_done = div_done;
		status.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= SEG;
			threshold_q <= SSTHRESH_RST;
			phase_q     <= PH_SLOW;
			dup_q       <= '0;
			highest_q   <= '0;
			last_q      <= '0;
			limit_q     <= SEG;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.wr) begin
				threshold_q <= cfg.data;
			end
			if (cmd.calc) begin
				window_q    <= win_n;
				threshold_q <= thr_n;
				phase_q     <= ph_n;
				dup_q       <= dup_n;
				highest_q   <= hi_n;
				last_q      <= last_n;
			end
			if (cmd.add_quot) begin
				window_q <= sat_add(window_q, quot);
			end
			if (cmd.limit) begin
				if (load_q) begin
					limit_q <= sat_add(last_q, window_q);
				end
				// Slow start hands over once the grown window reaches the threshold.
				if (chk_q && window_q >= threshold_q) begin
					phase_q <= PH_AVOID;
				end
			end
			if (cmd.put) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_func_q <= in_func;
			item_ack_q  <= in_ack;
		end
		if (cmd.calc) begin
			kind_q <= kind_n;
			fast_q <= fast_n;
			load_q <= load_n;
			chk_q  <= chk_n;
		end
		if (cmd.put) begin
			out_window_q    <= window_q;
			out_threshold_q <= threshold_q;
			out_limit_q     <= limit_q;
			out_phase_q     <= phase_q;
			out_kind_q      <= kind_q;
			out_fast_q      <= fast_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_window    = out_window_q;
	assign out_threshold = out_threshold_q;
	assign out_limit     = out_limit_q;
	assign out_phase     = out_phase_q;
	assign out_kind      = out_kind_q;
	assign out_fast      = out_fast_q;

endmodule

FILE: sv/tcwc_ctrl.sv
module tcwc_ctrl import tcwc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  ctrl_status_t status,
	output ctrl_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CALC  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_LIMIT = 3'd3;
	localparam logic [2:0] ST_PUT   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_n;

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				if (status.need_div) begin
					cmd.div_start = 1'b1;
					state_n       = ST_DIV;
				end else begin
					state_n = ST_LIMIT;
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					cmd.add_quot = 1'b1;
					state_n      = ST_LIMIT;
				end
			end
			ST_LIMIT: begin
				cmd.limit = 1'b1;
				state_n   = ST_PUT;
			end
			ST_PUT: begin
				// Wait until the result register can take the new word.
				if (status.out_free) begin
					cmd.put = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

FILE: sv/tcp_congestion_window_control.sv
// Channel   Role     Handshake      Word
// item      sink     valid/ready    func, ack_number
// result    source   valid/ready    window_bytes, threshold_bytes, send_limit,
//                                   phase, ack_kind, fast_retransmit
// apb       slave    psel/penable   initial_ssthresh at byte address 0
//
// One item is worked on at a time and passes CALC, LIMIT and PUT, with DIV after CALC when
// a new ack in congestion avoidance needs the window step from the restoring divider. PUT
// writes the word once the result register is free; the next item is taken back in IDLE.
// The result register holds a finished word while the engine takes the next item.
// Reset is asynchronous and active low and restores the engine state registers at once.
module tcp_congestion_window_control import tcwc_pkg::*; #(
	parameter int unsigned SEGMENT_BYTES = SEGMENT_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [WORD_W-1:0] pwdata,
	output logic [WORD_W-1:0] prdata,
	output logic              pready,
	tcwc_item_if.sink         item,
	tcwc_result_if.source     result
);

	cfg_wr_t      cfg;
	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	tcwc_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.status   (status),
		.cmd      (cmd)
	);

	tcwc_dp #(
		.SEGMENT_BYTES (SEGMENT_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.status        (status),
		.in_func       (item.func),
		.in_ack        (item.ack_number),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.out_window    (result.window_bytes),
		.out_threshold (result.threshold_bytes),
		.out_limit     (result.send_limit),
		.out_phase     (result.phase),
		.out_kind      (result.ack_kind),
		.out_fast      (result.fast_retransmit)
	);

endmodule

FILE: sv/tcwc_checker.sv
`include "assert_macros.svh"

module tcwc_checker import tcwc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [WORD_W-1:0] out_window,
	input logic [WORD_W-1:0] out_limit,
	input logic [1:0]        out_phase,
	input logic [1:0]        out_kind,
	input logic              out_fast
);

	// Fast recovery is only entered on a duplicate and leaves the engine in recovery.
	`ASSERT_SAME(a_fast_on_dup, clk, arst_n, out_valid && out_fast, out_kind == KIND_DUP && out_phase == PH_REC)

	// A timeout always drops back to slow start without a fast retransmit.
	`ASSERT_SAME(a_timeout_slow, clk, arst_n, out_valid && out_kind == KIND_TIMEOUT, out_phase == PH_SLOW && !out_fast)

	// A new ack always leaves fast recovery.
	`ASSERT_SAME(a_new_leaves_rec, clk, arst_n, out_valid && out_kind == KIND_NEW, out_phase != PH_REC && !out_fast)

	// The engine holds one item at a time, so it cannot take another right away.
	`ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_window) && $stable(out_limit))

endmodule

bind tcp_congestion_window_control tcwc_checker u_tcwc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_window (result.window_bytes),
	.out_limit  (result.send_limit),
	.out_phase  (result.phase),
	.out_kind   (result.ack_kind),
	.out_fast   (result.fast_retransmit)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tcwc_pkg::*;

	localparam int unsigned SEG = SEGMENT_BYTES_DEF;
	localparam logic [ADDR_W-1:0] REG_SSTHRESH = '0;
	localparam logic [7:0] DUP_CAP = 8'd255;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned IDLE_PCT = 7;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT = 600_000;
	localparam logic [WORD_W-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic              func;
		logic [WORD_W-1:0] ack;
	} seg_event_t;

	typedef struct packed {
		logic [WORD_W-1:0] win_b;
		logic [WORD_W-1:0] thr_b;
		logic [WORD_W-1:0] lim_b;
		logic [1:0]        phase;
		logic [1:0]        kind;
		logic              fast;
	} cwnd_report_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [WORD_W-1:0] pwdata = '0;
	logic [WORD_W-1:0] prdata;
	logic              pready;

	tcwc_item_if   item_bus ();
	tcwc_result_if res_bus ();

	tcp_congestion_window_control u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_bus),
		.result  (res_bus)
	);

	seg_event_t   pending_events[$];
	cwnd_report_t expected_reports[$];
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count = 0;
	bit           no_idle = 1'b0;
	bit           stall_go = 1'b0;
	bit           hold_used = 1'b0;
	int unsigned  hold_left = 0;
	logic [WORD_W-1:0] gen_high = '0;
	bit           long_dup_done = 1'b0;

	// Mirror of the engine state.
	logic [WORD_W-1:0] m_win;
	logic [WORD_W-1:0] m_thresh;
	logic [1:0]        m_phase;
	logic [7:0]        m_dups;
	logic [WORD_W-1:0] m_high;
	logic [WORD_W-1:0] m_last;
	logic [WORD_W-1:0] m_limit;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [WORD_W-1:0] add_clamped(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [63:0] total;
		total = 64'(a) + 64'(b);
		return (total > 64'(ALL_ONES)) ? ALL_ONES : total[WORD_W-1:0];
	endfunction

	function automatic void set_window(input logic [WORD_W-1:0] w);
		m_win = w;
		m_limit = add_clamped(m_last, w);
	endfunction

	function automatic void advance_cwnd(input logic fn, input logic [WORD_W-1:0] ack);
		cwnd_report_t rep;
		logic [WORD_W-1:0] step;
		rep.fast = 1'b0;
		if (fn) begin
			rep.kind = KIND_TIMEOUT;
			m_dups = '0;
			m_thresh = m_win >> 1;
			m_phase = PH_SLOW;
			set_window(SEG);
		end else begin
			m_last = ack;
			if (ack > m_high) begin
				rep.kind = KIND_NEW;
				m_high = ack;
				m_dups = '0;
				case (m_phase)
					PH_AVOID: begin
						if (m_win != 0) begin
							step = (SEG * SEG) / m_win;
							set_window(add_clamped(m_win, step));
						end else begin
							set_window(SEG);
						end
					end
					PH_REC: begin
						set_window(m_thresh);
						m_phase = PH_AVOID;
					end
					default: begin
						set_window(add_clamped(m_win, SEG));
						if (m_win >= m_thresh)
							m_phase = PH_AVOID;
					end
				endcase
			end else if (ack == m_high) begin
				rep.kind = KIND_DUP;
				if (m_dups != DUP_CAP)
					m_dups = m_dups + 1'b1;
				if (m_dups == DUP_FR_COUNT && m_phase != PH_REC) begin
					m_phase = PH_REC;
					m_thresh = m_win >> 1;
					set_window(add_clamped(m_thresh, 3 * SEG));
					rep.fast = 1'b1;
				end else if (m_phase == PH_REC) begin
					set_window(add_clamped(m_win, SEG));
				end
			end else begin
				rep.kind = KIND_STALE;
			end
		end
		rep.win_b = m_win;
		rep.thr_b = m_thresh;
		rep.lim_b = m_limit;
		rep.phase = m_phase;
		expected_reports.push_back(rep);
	endfunction

	function automatic void compare_field(input string name, input logic [WORD_W-1:0] want,
		input logic [WORD_W-1:0] got);
		if (want !== got) begin
			$error("%s expected 0x%08h got 0x%08h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Item driver: a word stays on the bus until it is taken.
	always @(posedge clk) begin
		seg_event_t ev;
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
		end else begin
			if (item_bus.valid && item_bus.ready)
				advance_cwnd(item_bus.func, item_bus.ack_number);
			if (!item_bus.valid || item_bus.ready) begin
				if (pending_events.size() != 0 &&
					(no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
					ev = pending_events.pop_front();
					item_bus.valid <= 1'b1;
					item_bus.func <= ev.func;
					item_bus.ack_number <= ev.ack;
				end else begin
					item_bus.valid <= 1'b0;
					item_bus.func <= 1'($urandom_range(0, 1));
					item_bus.ack_number <= $urandom();
				end
			end
		end
	end

	// Long hold-off of the result side, timed here once requested.
	always @(posedge clk) begin
		if (stall_go && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cwnd_report_t want;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (expected_reports.size() == 0) begin
					$error("result word arrived with no expectation pending");
					mismatch_count++;
				end else begin
					want = expected_reports.pop_front();
					compare_field("window_bytes", want.win_b, res_bus.window_bytes);
					compare_field("threshold_bytes", want.thr_b, res_bus.threshold_bytes);
					compare_field("send_limit", want.lim_b, res_bus.send_limit);
					compare_field("phase", 32'(want.phase), 32'(res_bus.phase));
					compare_field("ack_kind", 32'(want.kind), 32'(res_bus.ack_kind));
					compare_field("fast_retransmit", 32'(want.fast),
						32'(res_bus.fast_retransmit));
				end
			end
			res_bus.ready <= (hold_left == 0) && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_ack(input logic [WORD_W-1:0] ack);
		seg_event_t ev;
		ev.func = 1'b0;
		ev.ack = ack;
		pending_events.push_back(ev);
		if (ack > gen_high)
			gen_high = ack;
	endtask

	task automatic queue_timeout(input logic [WORD_W-1:0] junk);
		seg_event_t ev;
		ev.func = 1'b1;
		ev.ack = junk;
		pending_events.push_back(ev);
	endtask

	function automatic logic [WORD_W-1:0] next_new_ack();
		logic [WORD_W-1:0] inc;
		inc = $urandom_range(1, 4 * SEG);
		return (gen_high > ALL_ONES - inc) ? ALL_ONES : gen_high + inc;
	endfunction

	// Mostly well-formed flows: runs of new acks, runs of one to five duplicates into fast
	// recovery and recovery exits, mixed with timeouts, stale acks and jumps.
	task automatic queue_traffic(input int unsigned n);
		int unsigned count;
		int unsigned pick;
		int unsigned k;
		count = 0;
		while (count < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				k = $urandom_range(1, 12);
				repeat (k) queue_ack(next_new_ack());
				count += k;
			end else if (pick < 70) begin
				k = $urandom_range(1, 5);
				repeat (k) queue_ack(gen_high);
				count += k;
				if ($urandom_range(0, 1)) begin
					queue_ack(next_new_ack());
					count++;
				end
			end else if (pick < 78) begin
				queue_timeout($urandom());
				count++;
			end else if (pick < 88) begin
				queue_ack(gen_high == 0 ? '0 : $urandom_range(0, gen_high - 1));
				count++;
			end else if (pick < 97 || long_dup_done) begin
				if (gen_high < 32'hC000_0000)
					queue_ack($urandom());
				else
					queue_ack($urandom_range(0, gen_high));
				count++;
			end else begin
				// Long duplicate run drives the duplicate counter into saturation.
				long_dup_done = 1'b1;
				repeat (260) queue_ack(gen_high);
				count += 260;
			end
		end
	endtask

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || item_bus.valid || expected_reports.size() != 0);
	endtask

	task automatic cfg_write(input logic [WORD_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_SSTHRESH;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		m_thresh = value;
		@(negedge clk);
	endtask

	initial begin
		item_bus.valid = 1'b0;
		item_bus.func = 1'b0;
		item_bus.ack_number = '0;
		res_bus.ready = 1'b0;
		m_thresh = SSTHRESH_RST;
		m_phase = PH_SLOW;
		m_dups = '0;
		m_high = '0;
		m_last = '0;
		set_window(SEG);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset threshold: zero ack as duplicate, fast recovery in slow start,
		// recovery exit, congestion avoidance, timeouts and a stale ack.
		repeat (4) queue_ack('0);
		queue_ack(32'd4096);
		queue_ack(32'd8192);
		queue_timeout(ALL_ONES);
		queue_ack(32'd9000);
		queue_ack(32'd10000);
		queue_ack(32'd11000);
		queue_ack(32'd12000);
		queue_ack(32'd500);
		repeat (4) queue_ack(32'd12000);
		queue_ack(32'd13000);
		queue_timeout('0);
		wait_quiet();

		// Zero threshold: the first new ack leaves slow start at once.
		cfg_write('0);
		queue_ack(next_new_ack());
		queue_ack(next_new_ack());
		queue_traffic(400);
		stall_go = 1'b1;
		wait_quiet();

		cfg_write(ALL_ONES);
		no_idle = 1'b1;
		queue_traffic(400);
		wait_quiet();
		no_idle = 1'b0;

		cfg_write($urandom_range(SEG, 200000));
		queue_traffic(400);
		wait_quiet();

		cfg_write($urandom());
		queue_traffic(400);
		wait_quiet();

		// Back to the reset threshold, then acks at the top of the sequence space.
		cfg_write(SSTHRESH_RST);
		queue_traffic(300);
		queue_ack(32'hFFFF_F000);
		queue_ack(ALL_ONES);
		queue_ack(ALL_ONES);
		queue_ack('0);
		queue_timeout($urandom());
		wait_quiet();
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
